FILE: hw/rtl/sflp_pkg.sv
// ----------------------------------------------------------------------------
// sflp_pkg
// shared types and constants of the serial flash loader protocol sequencer
// ----------------------------------------------------------------------------
package sflp_pkg;

  // field widths fixed by the interface
  localparam int FUNC_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 14;
  localparam int EVENT_W     = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int TICK_W      = 8;
  localparam int RETRY_W     = 4;
  localparam int AREA_W      = 13;
  localparam int BCOUNT_W    = 4;

  // packet buffer holds at most eight bytes, indexed by the low byte count bits
  localparam int PBUF_DEPTH = 8;
  localparam int PBUF_AW    = 3;

  // result count of one batch: up to PACKET_WORDS writes plus the closing event
  localparam int BATCH_CNT_W = 4;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_AREA_START  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_AREA_END    = 2'd3;

  // configuration reset values
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET     = 8'd93;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RESET = 4'd3;
  localparam logic [AREA_W-1:0]  AREA_START_RESET  = 13'h0600;
  localparam logic [AREA_W-1:0]  AREA_END_RESET    = 13'h0FFF;

  // handshake sync bytes and the bit count of the high part of a flash word
  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
  localparam int                HI_BITS     = WORD_W - BYTE_W;

  typedef enum logic [EVENT_W-1:0] {
    EV_HANDSHAKE   = 3'd0,
    EV_ACK         = 3'd1,
    EV_WRITE       = 3'd2,
    EV_PKT_TIMEOUT = 3'd3,
    EV_ABORT       = 3'd4,
    EV_DONE        = 3'd5,
    EV_HS_TIMEOUT  = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    PH_HANDSHAKE = 2'd0,
    PH_DATA      = 2'd1,
    PH_IDLE      = 2'd2
  } phase_t;

  // one batch of results handed from the sequencer to the emitter
  typedef struct packed {
    logic [BATCH_CNT_W-1:0] count;
    logic                   is_write;
    event_t                 first_ev;
    event_t                 final_ev;
  } batch_t;

endpackage

FILE: hw/rtl/sflp_inreg.sv
// ----------------------------------------------------------------------------
// sflp_inreg
// input register: holds one accepted beat until the sequencer takes it
// ----------------------------------------------------------------------------
module sflp_inreg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sflp_pkg::FUNC_W-1:0]  func,
  input  logic [sflp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         take,
  output logic                         full,
  output logic [sflp_pkg::FUNC_W-1:0]  func_q,
  output logic [sflp_pkg::BYTE_W-1:0]  byte_q
);

  logic accept;

  // stall only while the held beat is not leaving this cycle
  assign in_stall = full && !take;
  assign accept   = in_valid && !in_stall;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      byte_q <= rx_byte;
    end
  end

endmodule

FILE: hw/rtl/sflp_core.sv
// ----------------------------------------------------------------------------
// sflp_core
// protocol sequencer: configuration, session state and at most one batch per beat
// ----------------------------------------------------------------------------
module sflp_core #(
  parameter int PACKET_WORDS = 4,
  parameter int ADDRESS_BITS = 13
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_write,
  input  logic [sflp_pkg::CFG_INDEX_W-1:0]             cfg_index,
  input  logic [sflp_pkg::CFG_DATA_W-1:0]              cfg_data,
  input  logic                                         item_valid,
  input  logic [sflp_pkg::FUNC_W-1:0]                  item_func,
  input  logic [sflp_pkg::BYTE_W-1:0]                  item_byte,
  input  logic                                         batch_ready,
  output logic                                         item_take,
  output logic                                         batch_load,
  output sflp_pkg::batch_t                             batch,
  output logic [ADDRESS_BITS-1:0]                      batch_base,
  output logic [PACKET_WORDS-1:0][sflp_pkg::WORD_W-1:0] batch_words
);

  localparam int PACKET_BYTES = 2 * PACKET_WORDS;
  localparam int CMP_W        = ADDRESS_BITS + 2;

  // configuration registers
  logic [sflp_pkg::TICK_W-1:0]  timeout_ticks;
  logic [sflp_pkg::RETRY_W-1:0] max_retries;
  logic [sflp_pkg::AREA_W-1:0]  area_start;
  logic [sflp_pkg::AREA_W-1:0]  area_end;

  // session state
  sflp_pkg::phase_t              phase, phase_next;
  logic [sflp_pkg::BYTE_W-1:0]   prev_byte, prev_byte_next;
  logic [sflp_pkg::TICK_W-1:0]   tick_count, tick_count_next;
  logic [sflp_pkg::BCOUNT_W-1:0] byte_count, byte_count_next;
  logic [ADDRESS_BITS-1:0]       write_address, write_address_next;
  logic [sflp_pkg::RETRY_W-1:0]  retry_count, retry_count_next;
  logic [sflp_pkg::BYTE_W-1:0]   pbuf [sflp_pkg::PBUF_DEPTH];

  // working values
  logic                          has_results;
  logic                          pbuf_we;
  logic [sflp_pkg::PBUF_AW-1:0]  pbuf_idx;
  logic [sflp_pkg::BYTE_W-1:0]   pbuf_now [sflp_pkg::PBUF_DEPTH];
  logic [sflp_pkg::TICK_W-1:0]   tick_inc;
  logic                          expired;
  logic [sflp_pkg::BCOUNT_W-1:0] bc_inc;
  logic                          packet_end;
  logic [sflp_pkg::RETRY_W-1:0]  retry_inc;
  logic [CMP_W-1:0]              packet_top;
  logic                          area_full;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= sflp_pkg::TIMEOUT_RESET;
      max_retries   <= sflp_pkg::MAX_RETRIES_RESET;
      area_start    <= sflp_pkg::AREA_START_RESET;
      area_end      <= sflp_pkg::AREA_END_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sflp_pkg::CFG_TIMEOUT:     timeout_ticks <= cfg_data[sflp_pkg::TICK_W-1:0];
        sflp_pkg::CFG_MAX_RETRIES: max_retries   <= cfg_data[sflp_pkg::RETRY_W-1:0];
        sflp_pkg::CFG_AREA_START:  area_start    <= cfg_data[sflp_pkg::AREA_W-1:0];
        sflp_pkg::CFG_AREA_END:    area_end      <= cfg_data[sflp_pkg::AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // tick timeout, byte count and packet end arithmetic
  assign tick_inc   = tick_count + sflp_pkg::TICK_W'(1);
  assign expired    = tick_inc >= timeout_ticks;
  assign bc_inc     = byte_count + sflp_pkg::BCOUNT_W'(1);
  assign packet_end = {1'b0, bc_inc} >= (sflp_pkg::BCOUNT_W + 1)'(PACKET_BYTES);
  assign retry_inc  = retry_count + sflp_pkg::RETRY_W'(1);
  assign packet_top = CMP_W'(write_address) + CMP_W'(2 * PACKET_WORDS - 1);
  assign area_full  = packet_top > CMP_W'(area_end);
  assign pbuf_idx   = byte_count[sflp_pkg::PBUF_AW-1:0];

  // buffer contents with the current byte merged in
  always_comb begin
    for (int k = 0; k < sflp_pkg::PBUF_DEPTH; k++) begin
      pbuf_now[k] = (pbuf_idx == sflp_pkg::PBUF_AW'(k)) ? item_byte : pbuf[k];
    end
  end

  // little-endian byte pairs into flash words
  always_comb begin
    for (int i = 0; i < PACKET_WORDS; i++) begin
      batch_words[i] = {pbuf_now[(2 * i + 1) % sflp_pkg::PBUF_DEPTH][sflp_pkg::HI_BITS-1:0],
                        pbuf_now[(2 * i) % sflp_pkg::PBUF_DEPTH]};
    end
  end

  assign batch_base = {write_address[ADDRESS_BITS-1:2], 2'b00};

  // next state and the batch for the held beat
  always_comb begin
    phase_next         = phase;
    prev_byte_next     = prev_byte;
    tick_count_next    = tick_count;
    byte_count_next    = byte_count;
    write_address_next = write_address;
    retry_count_next   = retry_count;
    pbuf_we            = 1'b0;
    has_results        = 1'b0;
    batch.count        = '0;
    batch.is_write     = 1'b0;
    batch.first_ev     = sflp_pkg::EV_ACK;
    batch.final_ev     = sflp_pkg::EV_ACK;

    if (item_func == sflp_pkg::FUNC_RESTART) begin
      phase_next       = sflp_pkg::PH_HANDSHAKE;
      prev_byte_next   = '0;
      tick_count_next  = '0;
      byte_count_next  = '0;
      retry_count_next = '0;
    end else if (item_func == sflp_pkg::FUNC_BYTE || item_func == sflp_pkg::FUNC_TICK) begin
      case (phase)
        sflp_pkg::PH_HANDSHAKE: begin
          if (item_func == sflp_pkg::FUNC_BYTE) begin
            prev_byte_next = item_byte;
            if (prev_byte == sflp_pkg::SYNC_FIRST && item_byte == sflp_pkg::SYNC_SECOND) begin
              has_results        = 1'b1;
              batch.count        = sflp_pkg::BATCH_CNT_W'(2);
              batch.first_ev     = sflp_pkg::EV_HANDSHAKE;
              batch.final_ev     = sflp_pkg::EV_ACK;
              phase_next         = sflp_pkg::PH_DATA;
              write_address_next = ADDRESS_BITS'(area_start);
              byte_count_next    = '0;
              tick_count_next    = '0;
              retry_count_next   = '0;
            end
          end else begin
            tick_count_next = expired ? '0 : tick_inc;
            if (expired) begin
              has_results    = 1'b1;
              batch.count    = sflp_pkg::BATCH_CNT_W'(1);
              batch.first_ev = sflp_pkg::EV_HS_TIMEOUT;
              batch.final_ev = sflp_pkg::EV_HS_TIMEOUT;
              phase_next     = sflp_pkg::PH_IDLE;
            end
          end
        end
        sflp_pkg::PH_DATA: begin
          if (item_func == sflp_pkg::FUNC_BYTE) begin
            pbuf_we         = 1'b1;
            byte_count_next = bc_inc;
            if (packet_end) begin
              has_results        = 1'b1;
              batch.count        = sflp_pkg::BATCH_CNT_W'(PACKET_WORDS + 1);
              batch.is_write     = 1'b1;
              batch.first_ev     = sflp_pkg::EV_WRITE;
              byte_count_next    = '0;
              retry_count_next   = '0;
              write_address_next = write_address + ADDRESS_BITS'(PACKET_WORDS);
              if (area_full) begin
                batch.final_ev = sflp_pkg::EV_DONE;
                phase_next     = sflp_pkg::PH_IDLE;
              end else begin
                batch.final_ev  = sflp_pkg::EV_ACK;
                tick_count_next = '0;
              end
            end
          end else begin
            tick_count_next = expired ? '0 : tick_inc;
            if (expired) begin
              has_results      = 1'b1;
              batch.count      = sflp_pkg::BATCH_CNT_W'(2);
              batch.first_ev   = sflp_pkg::EV_PKT_TIMEOUT;
              byte_count_next  = '0;
              retry_count_next = retry_inc;
              if (retry_inc >= max_retries) begin
                batch.final_ev = sflp_pkg::EV_ABORT;
                phase_next     = sflp_pkg::PH_IDLE;
              end else begin
                batch.final_ev = sflp_pkg::EV_ACK;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // a beat without results never waits for the emitter
  assign item_take  = item_valid && (batch_ready || !has_results);
  assign batch_load = item_valid && batch_ready && has_results;

  // session state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sflp_pkg::PH_HANDSHAKE;
      prev_byte     <= '0;
      tick_count    <= '0;
      byte_count    <= '0;
      write_address <= '0;
      retry_count   <= '0;
    end else if (item_take) begin
      phase         <= phase_next;
      prev_byte     <= prev_byte_next;
      tick_count    <= tick_count_next;
      byte_count    <= byte_count_next;
      write_address <= write_address_next;
      retry_count   <= retry_count_next;
    end
  end

  // packet byte buffer
  always_ff @(posedge clk) begin
    if (item_take && pbuf_we) begin
      pbuf[pbuf_idx] <= item_byte;
    end
  end

endmodule

FILE: hw/rtl/sflp_emit.sv
// ----------------------------------------------------------------------------
// sflp_emit
// result emitter: holds one batch and sends one result each unstalled cycle
// ----------------------------------------------------------------------------
module sflp_emit #(
  parameter int PACKET_WORDS = 4,
  parameter int ADDRESS_BITS = 13
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         load,
  input  sflp_pkg::batch_t                             batch,
  input  logic [ADDRESS_BITS-1:0]                      base,
  input  logic [PACKET_WORDS-1:0][sflp_pkg::WORD_W-1:0] words,
  output logic                                         ready,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [sflp_pkg::EVENT_W-1:0]                 event_res,
  output logic [ADDRESS_BITS-1:0]                      flash_address,
  output logic [sflp_pkg::WORD_W-1:0]                  flash_word,
  output logic                                         last
);

  logic                                          held;
  sflp_pkg::batch_t                              cur;
  logic [ADDRESS_BITS-1:0]                       cur_base;
  logic [PACKET_WORDS-1:0][sflp_pkg::WORD_W-1:0] cur_words;
  logic [sflp_pkg::BATCH_CNT_W-1:0]              idx;
  logic                                          is_final;
  logic                                          in_writes;
  logic                                          send;
  logic [sflp_pkg::WORD_W-1:0]                   word_sel;

  assign is_final  = idx == (cur.count - sflp_pkg::BATCH_CNT_W'(1));
  assign in_writes = cur.is_write && (idx < sflp_pkg::BATCH_CNT_W'(PACKET_WORDS));
  assign send      = held && !out_stall;
  assign ready     = !held || (send && is_final);

  // word select over the packet
  always_comb begin
    word_sel = '0;
    for (int k = 0; k < PACKET_WORDS; k++) begin
      if (idx == sflp_pkg::BATCH_CNT_W'(k)) begin
        word_sel = cur_words[k];
      end
    end
  end

  // result fields from the held batch
  always_comb begin
    out_valid     = held;
    last          = is_final;
    flash_address = '0;
    flash_word    = '0;
    if (in_writes) begin
      event_res     = sflp_pkg::EV_WRITE;
      flash_address = cur_base + ADDRESS_BITS'(idx);
      flash_word    = word_sel;
    end else if (is_final) begin
      event_res = cur.final_ev;
    end else begin
      event_res = cur.first_ev;
    end
  end

  // batch occupancy and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      held <= 1'b1;
      idx  <= '0;
    end else if (send) begin
      if (is_final) begin
        held <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + sflp_pkg::BATCH_CNT_W'(1);
      end
    end
  end

  // batch payload
  always_ff @(posedge clk) begin
    if (load) begin
      cur       <= batch;
      cur_base  <= base;
      cur_words <= words;
    end
  end

endmodule

FILE: hw/rtl/serial_flash_loader_protocol.sv
// ----------------------------------------------------------------------------
// serial_flash_loader_protocol
// loader sequencer: handshake, packet gathering, flash writes and timeouts
// ----------------------------------------------------------------------------
//  channel  | signals                                  | beat
//  ---------+------------------------------------------+---------------------
//  in       | in_valid, in_stall, func, rx_byte        | one byte, tick or restart
//  out      | out_valid, out_stall, event_res,         | one protocol event
//           | flash_address, flash_word, last          |
//  cfg      | cfg_write, cfg_index, cfg_data           | one register write
//
//  a beat is registered in the input register, then its batch in the emitter;
//  its first result can be taken once that batch is held in the emitter
//  a beat yields up to PACKET_WORDS + 1 results, sent at one per cycle from the
//  emitter while out_stall is low, so the output port sets the rate: one beat per
//  cycle when it yields at most one result; more results hold up the next beat
//  a beat with results moves on at the edge that sends the last result before it;
//  a beat without results moves on at once
//  rst is synchronous: clears control state and restores register defaults
//  out_stall holds the current result; in_stall rises only when both stages wait
// ----------------------------------------------------------------------------
module serial_flash_loader_protocol #(
  parameter int PACKET_WORDS = 4,
  parameter int ADDRESS_BITS = 13
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sflp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sflp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sflp_pkg::FUNC_W-1:0]      func,
  input  logic [sflp_pkg::BYTE_W-1:0]      rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sflp_pkg::EVENT_W-1:0]     event_res,
  output logic [ADDRESS_BITS-1:0]          flash_address,
  output logic [sflp_pkg::WORD_W-1:0]      flash_word,
  output logic                             last
);

  logic                                          item_valid;
  logic [sflp_pkg::FUNC_W-1:0]                   item_func;
  logic [sflp_pkg::BYTE_W-1:0]                   item_byte;
  logic                                          item_take;
  logic                                          batch_ready;
  logic                                          batch_load;
  sflp_pkg::batch_t                              batch;
  logic [ADDRESS_BITS-1:0]                       batch_base;
  logic [PACKET_WORDS-1:0][sflp_pkg::WORD_W-1:0] batch_words;

  // input register
  sflp_inreg u_inreg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .rx_byte  (rx_byte),
    .take     (item_take),
    .full     (item_valid),
    .func_q   (item_func),
    .byte_q   (item_byte)
  );

  // protocol sequencer
  sflp_core #(
    .PACKET_WORDS (PACKET_WORDS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_func   (item_func),
    .item_byte   (item_byte),
    .batch_ready (batch_ready),
    .item_take   (item_take),
    .batch_load  (batch_load),
    .batch       (batch),
    .batch_base  (batch_base),
    .batch_words (batch_words)
  );

  // result emitter
  sflp_emit #(
    .PACKET_WORDS (PACKET_WORDS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (batch_load),
    .batch         (batch),
    .base          (batch_base),
    .words         (batch_words),
    .ready         (batch_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .flash_address (flash_address),
    .flash_word    (flash_word),
    .last          (last)
  );

endmodule
